FILE: hw/rtl/bpt_pkg.sv
// Shared widths, shifts, codes and payload types of the barometer compensation datapath
package bpt_pkg;

  // Field and register widths
  localparam int RawW    = 24;
  localparam int CalW    = 16;
  localparam int NumCal  = 6;
  localparam int CfgIdxW = $clog2(NumCal);
  localparam int TempW   = 20;
  localparam int PresW   = 32;

  // Temperature path
  localparam int TdW      = RawW + 1;
  localparam int RefSh    = 8;
  localparam int MulW     = TdW + CalW + 1;
  localparam int TCoeffSh = 23;
  localparam int QtW      = MulW - TCoeffSh;
  localparam int SqW      = 2 * RawW;
  localparam int TCorrSh  = 31;
  localparam int TcW      = SqW - TCorrSh;
  localparam int SqCW     = 35;
  localparam int CorrW    = SqCW + 4;

  // Offset and sensitivity path
  localparam int OffTcSh  = 7;
  localparam int SensTcSh = 8;
  localparam int OffSh    = 16;
  localparam int SensSh   = 15;
  localparam int GainW    = 40;

  // Pressure path
  localparam int LoW    = 20;
  localparam int ProdW  = 64;
  localparam int ProdSh = 21;
  localparam int QW     = ProdW - ProdSh;
  localparam int DiffW  = QW + 1;
  localparam int PresSh = 15;
  localparam int PresQW = DiffW - PresSh;

  localparam logic signed [TempW-1:0] TBase    = 20'sd2000;
  localparam logic signed [TempW-1:0] TCold    = -20'sd1500;
  localparam logic signed [TempW-1:0] ColdSpan = TBase - TCold;

  typedef enum logic [CfgIdxW-1:0] {
    CAL_SENS       = 3'd0,
    CAL_OFFSET     = 3'd1,
    CAL_SENS_TC    = 3'd2,
    CAL_OFFSET_TC  = 3'd3,
    CAL_REF_TEMP   = 3'd4,
    CAL_TEMP_COEFF = 3'd5
  } cal_idx_e;

  typedef struct packed {
    logic [CalW-1:0] sens;
    logic [CalW-1:0] offset;
    logic [CalW-1:0] sens_tc;
    logic [CalW-1:0] offset_tc;
    logic [CalW-1:0] ref_temp;
    logic [CalW-1:0] temp_coeff;
  } cal_t;

  typedef struct packed {
    logic        [RawW-1:0]  raw_p;
    logic signed [GainW-1:0] offs;
    logic signed [GainW-1:0] gain;
    logic signed [TempW-1:0] temp;
  } comp_t;

  typedef struct packed {
    logic signed [TempW-1:0] temp;
    logic signed [PresW-1:0] pres;
    logic                    pres_valid;
  } res_t;

endpackage

FILE: hw/rtl/bpt_if.sv
// Valid/ready channel interfaces for raw conversions in and compensated results out
interface bpt_in_if;
  logic                         valid;
  logic                         ready;
  logic [bpt_pkg::RawW-1:0]     raw_pressure;
  logic [bpt_pkg::RawW-1:0]     raw_temperature;

  modport source (output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface bpt_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [bpt_pkg::TempW-1:0]    temp_centi;
  logic signed [bpt_pkg::PresW-1:0]    pressure_pa;
  logic                                pressure_valid;

  modport source (output valid, output temp_centi, output pressure_pa, output pressure_valid,
                  input ready);
  modport sink   (input valid, input temp_centi, input pressure_pa, input pressure_valid,
                  output ready);
endinterface

FILE: hw/rtl/bpt_cfg.sv
// Calibration word registers written through the configuration port
module bpt_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bpt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bpt_pkg::CalW-1:0]    cfg_data_i,
  output bpt_pkg::cal_t               cal_o
);
  import bpt_pkg::*;

  cal_t cal_q, cal_d;

  always_comb begin
    cal_d = cal_q;
    if (cfg_we_i) begin
      case (cal_idx_e'(cfg_idx_i))
        CAL_SENS:       cal_d.sens       = cfg_data_i;
        CAL_OFFSET:     cal_d.offset     = cfg_data_i;
        CAL_SENS_TC:    cal_d.sens_tc    = cfg_data_i;
        CAL_OFFSET_TC:  cal_d.offset_tc  = cfg_data_i;
        CAL_REF_TEMP:   cal_d.ref_temp   = cfg_data_i;
        CAL_TEMP_COEFF: cal_d.temp_coeff = cfg_data_i;
        default:        cal_d = cal_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else begin
      cal_q <= cal_d;
    end
  end

  assign cal_o = cal_q;

endmodule

FILE: hw/rtl/bpt_front.sv
// Six-stage temperature, offset and sensitivity pipeline
module bpt_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bpt_pkg::cal_t            cal_i,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [bpt_pkg::RawW-1:0] raw_pressure_i,
  input  logic [bpt_pkg::RawW-1:0] raw_temperature_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output bpt_pkg::comp_t           data_o
);
  import bpt_pkg::*;

  localparam int NStg = 6;

  logic [NStg-1:0] v_q;
  logic [NStg-1:0] en;

  // Stage 1: temperature difference
  logic        [RawW-1:0]  rp1_q;
  logic signed [TdW-1:0]   td1_q, td1_d;
  // Stage 2: products with the difference
  logic        [RawW-1:0]  rp2_q;
  logic signed [MulW-1:0]  mt2_q, mt2_d, mo2_q, mo2_d, ms2_q, ms2_d;
  logic signed [2*TdW-1:0] sq_full;
  logic        [SqW-1:0]   sq2_q;
  // Stage 3: truncating scale-downs
  logic        [RawW-1:0]           rp3_q;
  logic signed [MulW-1:0]           mt_b, mo_b, ms_b;
  logic signed [QtW-1:0]            qt3_q;
  logic        [TcW-1:0]            tc3_q;
  logic signed [MulW-OffTcSh-1:0]   offt3_q;
  logic signed [MulW-SensTcSh-1:0]  senst3_q;
  // Stage 4: first-order temperature, squares, bases
  logic        [RawW-1:0]    rp4_q;
  logic signed [TempW-1:0]   tfirst_c, e_val, tfin4_q, tfin4_d;
  logic signed [2*QtW-1:0]   d_sq;
  logic signed [2*TempW-1:0] e_sq;
  logic        [SqCW-1:0]    d2_4_q, e2_4_q;
  logic                      lt4_q, cold4_q;
  logic signed [GainW-1:0]   offb4_q, offb4_d, gainb4_q, gainb4_d;
  // Stage 5: second-order corrections
  logic        [RawW-1:0]  rp5_q;
  logic signed [TempW-1:0] tfin5_q;
  logic signed [GainW-1:0] offb5_q, gainb5_q;
  logic        [CorrW-1:0] d5x, e7x, e11x, offc5_q, offc5_d, sensc5_q, sensc5_d;
  // Stage 6: offset and sensitivity
  logic        [RawW-1:0]  rp6_q;
  logic signed [TempW-1:0] tfin6_q;
  logic signed [GainW-1:0] offs6_q, gain6_q;

  // A stage loads when it is empty or its content moves on
  always_comb begin
    en[NStg-1] = !v_q[NStg-1] || ready_i;
    for (int k = NStg - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NStg; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Stage 1
  assign td1_d = $signed({1'b0, raw_temperature_i})
               - $signed({1'b0, cal_i.ref_temp, {RefSh{1'b0}}});

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      rp1_q <= raw_pressure_i;
      td1_q <= td1_d;
    end
  end

  // Stage 2
  assign mt2_d   = td1_q * $signed({1'b0, cal_i.temp_coeff});
  assign mo2_d   = td1_q * $signed({1'b0, cal_i.offset_tc});
  assign ms2_d   = td1_q * $signed({1'b0, cal_i.sens_tc});
  assign sq_full = td1_q * td1_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      rp2_q <= rp1_q;
      mt2_q <= mt2_d;
      mo2_q <= mo2_d;
      ms2_q <= ms2_d;
      sq2_q <= sq_full[SqW-1:0];
    end
  end

  // Stage 3: add the rounding bias on negative values so the shift truncates toward zero
  assign mt_b = mt2_q + $signed({{(MulW-TCoeffSh){1'b0}}, {TCoeffSh{mt2_q[MulW-1]}}});
  assign mo_b = mo2_q + $signed({{(MulW-OffTcSh){1'b0}}, {OffTcSh{mo2_q[MulW-1]}}});
  assign ms_b = ms2_q + $signed({{(MulW-SensTcSh){1'b0}}, {SensTcSh{ms2_q[MulW-1]}}});

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      rp3_q    <= rp2_q;
      qt3_q    <= mt_b[MulW-1:TCoeffSh];
      tc3_q    <= sq2_q[SqW-1:TCorrSh];
      offt3_q  <= mo_b[MulW-1:OffTcSh];
      senst3_q <= ms_b[MulW-1:SensTcSh];
    end
  end

  // Stage 4: the distance below the base temperature is the scaled quotient itself
  assign tfirst_c = TempW'(qt3_q) + TBase;
  assign e_val    = TempW'(qt3_q) + ColdSpan;
  assign d_sq     = qt3_q * qt3_q;
  assign e_sq     = e_val * e_val;
  assign tfin4_d  = qt3_q[QtW-1] ? (tfirst_c - $signed(TempW'(tc3_q))) : tfirst_c;
  assign offb4_d  = GainW'($signed({1'b0, cal_i.offset, {OffSh{1'b0}}})) + GainW'(offt3_q);
  assign gainb4_d = GainW'($signed({1'b0, cal_i.sens, {SensSh{1'b0}}})) + GainW'(senst3_q);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      rp4_q    <= rp3_q;
      tfin4_q  <= tfin4_d;
      d2_4_q   <= d_sq[SqCW-1:0];
      e2_4_q   <= e_sq[SqCW-1:0];
      lt4_q    <= qt3_q[QtW-1];
      cold4_q  <= (TempW'(qt3_q) < -ColdSpan);
      offb4_q  <= offb4_d;
      gainb4_q <= gainb4_d;
    end
  end

  // Stage 5
  always_comb begin
    d5x      = (CorrW'(d2_4_q) << 2) + CorrW'(d2_4_q);
    e7x      = (CorrW'(e2_4_q) << 3) - CorrW'(e2_4_q);
    e11x     = (CorrW'(e2_4_q) << 3) + (CorrW'(e2_4_q) << 1) + CorrW'(e2_4_q);
    offc5_d  = '0;
    sensc5_d = '0;
    if (lt4_q) begin
      offc5_d  = (d5x >> 1) + (cold4_q ? e7x : '0);
      sensc5_d = (d5x >> 2) + (cold4_q ? (e11x >> 1) : '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      rp5_q    <= rp4_q;
      tfin5_q  <= tfin4_q;
      offb5_q  <= offb4_q;
      gainb5_q <= gainb4_q;
      offc5_q  <= offc5_d;
      sensc5_q <= sensc5_d;
    end
  end

  // Stage 6
  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      rp6_q   <= rp5_q;
      tfin6_q <= tfin5_q;
      offs6_q <= offb5_q - $signed(GainW'(offc5_q));
      gain6_q <= gainb5_q - $signed(GainW'(sensc5_q));
    end
  end

  assign data_o.raw_p = rp6_q;
  assign data_o.offs  = offs6_q;
  assign data_o.gain  = gain6_q;
  assign data_o.temp  = tfin6_q;

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_o |-> (&v_q))
    else $error("front refuses a beat with a bubble in the pipe");

  a_corr_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[4] |-> (offc5_q >= sensc5_q))
    else $error("offset correction below sensitivity correction");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i) |=> (valid_o && $stable(data_o)))
    else $error("front dropped or changed a stalled beat");

endmodule

FILE: hw/rtl/bpt_back.sv
// Five-stage compensated pressure pipeline with split wide product
module bpt_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  bpt_pkg::comp_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output bpt_pkg::res_t  data_o
);
  import bpt_pkg::*;

  localparam int NStg = 5;
  localparam int HiW  = RawW + 1 + GainW - LoW;

  logic [NStg-1:0] v_q;
  logic [NStg-1:0] en;

  logic        [RawW+LoW-1:0] pplo1_q;
  logic signed [HiW-1:0]      pphi1_q;
  logic signed [GainW-1:0]    offs1_q, offs2_q, offs3_q;
  logic signed [TempW-1:0]    temp1_q, temp2_q, temp3_q, temp4_q;
  logic signed [ProdW-1:0]    prod2_q, prod_b;
  logic signed [QW-1:0]       q3_q;
  logic signed [DiffW-1:0]    diff4_q, diff_b;
  logic signed [PresQW-1:0]   pq;
  res_t                       res5_q;

  always_comb begin
    en[NStg-1] = !v_q[NStg-1] || ready_i;
    for (int k = NStg - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NStg; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Stage 1: partial products on the low and high halves of the sensitivity
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      pplo1_q <= data_i.raw_p * data_i.gain[LoW-1:0];
      pphi1_q <= $signed({1'b0, data_i.raw_p}) * $signed(data_i.gain[GainW-1:LoW]);
      offs1_q <= data_i.offs;
      temp1_q <= data_i.temp;
    end
  end

  // Stage 2: recombine
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      prod2_q <= (ProdW'(pphi1_q) <<< LoW) + $signed(ProdW'(pplo1_q));
      offs2_q <= offs1_q;
      temp2_q <= temp1_q;
    end
  end

  // Stage 3: scale down, truncating toward zero
  assign prod_b = prod2_q + $signed({{(ProdW-ProdSh){1'b0}}, {ProdSh{prod2_q[ProdW-1]}}});

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      q3_q    <= prod_b[ProdW-1:ProdSh];
      offs3_q <= offs2_q;
      temp3_q <= temp2_q;
    end
  end

  // Stage 4: remove offset
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      diff4_q <= DiffW'(q3_q) - DiffW'(offs3_q);
      temp4_q <= temp3_q;
    end
  end

  // Stage 5: final scale; the quotient always fits the signed 32-bit range
  assign diff_b = diff4_q + $signed({{(DiffW-PresSh){1'b0}}, {PresSh{diff4_q[DiffW-1]}}});
  assign pq     = diff_b[DiffW-1:PresSh];

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      res5_q.temp       <= temp4_q;
      res5_q.pres       <= PresW'(pq);
      res5_q.pres_valid <= !pq[PresQW-1] && (pq != '0);
    end
  end

  assign data_o = res5_q;

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_o |-> (&v_q))
    else $error("back refuses a beat with a bubble in the pipe");

  a_trunc_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en[2] && v_q[1]) |=> ((q3_q == '0) || (q3_q[QW-1] == $past(prod2_q[ProdW-1]))))
    else $error("scaled product changed sign");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i) |=> (valid_o && $stable(data_o)))
    else $error("back dropped or changed a stalled beat");

endmodule

FILE: hw/rtl/baro_pressure_temp_compensation.sv
// Top level of the second-order barometric pressure and temperature compensation
// Throughput: one beat per cycle while the output accepts; each of the eleven register
// stages holds one item, and the widest path is a 25x25 multiply or a 64-bit add.
// Reset clears the calibration words to zero and empties the pipeline; ready runs back
// combinationally from the output, and a stall holds each occupied stage that has no
// empty stage after it.
module baro_pressure_temp_compensation (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bpt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bpt_pkg::CalW-1:0]    cfg_data_i,
  bpt_in_if.sink                      in_i,
  bpt_out_if.source                   out_o
);
  import bpt_pkg::*;

  cal_t  cal;
  comp_t comp;
  res_t  res;
  logic  mid_valid;
  logic  mid_ready;

  bpt_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cal_o      (cal)
  );

  bpt_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cal_i             (cal),
    .valid_i           (in_i.valid),
    .ready_o           (in_i.ready),
    .raw_pressure_i    (in_i.raw_pressure),
    .raw_temperature_i (in_i.raw_temperature),
    .valid_o           (mid_valid),
    .ready_i           (mid_ready),
    .data_o            (comp)
  );

  bpt_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mid_valid),
    .ready_o (mid_ready),
    .data_i  (comp),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (res)
  );

  assign out_o.temp_centi     = res.temp;
  assign out_o.pressure_pa    = res.pres;
  assign out_o.pressure_valid = res.pres_valid;

endmodule
